### rtl/dhpd_pkg.sv
`default_nettype none
package dhpd_pkg;

    // Pair position counter width (wraps at 64)
    localparam int POS_W  = 6;
    // Dots held per queued item: two carried dots plus fourteen new ones
    localparam int DOTS_W = 16;
    // Pixel index within one item, up to 16 pixels
    localparam int PIX_W  = 4;

    // Last pixel index for each item kind
    localparam logic [PIX_W-1:0] LAST_MONO = 4'd13;
    localparam logic [PIX_W-1:0] LAST_EVEN = 4'd11;
    localparam logic [PIX_W-1:0] LAST_ODD  = 4'd15;

    localparam logic [31:0] MONO_ON  = 32'hFFFF_FFFF;
    localparam logic [31:0] MONO_OFF = 32'hFF00_0000;

    // One classified item passed from front to back
    typedef struct packed {
        logic [DOTS_W-1:0] dots;
        logic              mono;
        logic              odd;
        logic              line_end;
    } t_job;

    // Fixed 16-color palette, B8G8R8A8 with alpha on top
    function automatic logic [31:0] palette(input logic [3:0] idx);
        logic [31:0] color;
        case (idx)
            4'd0:    color = 32'hFF00_0000;
            4'd1:    color = 32'hFFDD_2266;
            4'd2:    color = 32'hFF00_0099;
            4'd3:    color = 32'hFFDD_0044;
            4'd4:    color = 32'hFF00_2200;
            4'd5:    color = 32'hFF55_5555;
            4'd6:    color = 32'hFF00_22CC;
            4'd7:    color = 32'hFF66_AAFF;
            4'd8:    color = 32'hFF88_5500;
            4'd9:    color = 32'hFFFF_4400;
            4'd10:   color = 32'hFFAA_AAAA;
            4'd11:   color = 32'hFFFF_8888;
            4'd12:   color = 32'hFF00_DD00;
            4'd13:   color = 32'hFFFF_FF00;
            4'd14:   color = 32'hFF44_FFDD;
            default: color = 32'hFFFF_FFFF;
        endcase
        return color;
    endfunction

endpackage
`default_nettype wire

### rtl/dhpd_pair_if.sv
`default_nettype none
interface dhpd_pair_if;
    logic       valid;
    logic       ready;
    logic [7:0] aux_byte;
    logic [7:0] main_byte;

    modport source (output valid, output aux_byte, output main_byte, input ready);
    modport sink   (input valid, input aux_byte, input main_byte, output ready);
endinterface
`default_nettype wire

### rtl/dhpd_pixel_if.sv
`default_nettype none
interface dhpd_pixel_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_color;
    logic        last;
    logic        line_end;

    modport source (output valid, output pixel_color, output last, output line_end,
                    input ready);
    modport sink   (input valid, input pixel_color, input last, input line_end,
                    output ready);
endinterface
`default_nettype wire

### rtl/dhpd_front.sv
`default_nettype none
module dhpd_front #(
    parameter int PAIRS_PER_LINE = 40
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_mono,
    dhpd_pair_if.sink         i_pair,
    input  wire logic         i_full,
    output logic              o_push,
    output dhpd_pkg::t_job    o_job
);
    import dhpd_pkg::*;

    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_odd, n_odd;
    logic [1:0]       r_carry, n_carry;
    logic [13:0]      pair_dots;
    logic             end_of_line;

    // Take a pair whenever the queue has room
    assign i_pair.ready = !i_full;
    assign o_push       = i_pair.valid && !i_full;

    assign pair_dots   = {i_pair.main_byte[6:0], i_pair.aux_byte[6:0]};
    assign end_of_line = ({1'b0, r_pos} + 7'd1) >= 7'(PAIRS_PER_LINE);

    // Classify: odd color pairs prepend the carried dots
    always_comb begin
        o_job.mono     = i_mono;
        o_job.odd      = r_odd;
        o_job.line_end = end_of_line;
        if (r_odd && !i_mono) begin
            o_job.dots = {pair_dots, r_carry};
        end else begin
            o_job.dots = {2'b00, pair_dots};
        end
    end

    // Line position, parity and carried dots
    always_comb begin
        n_pos   = r_pos;
        n_odd   = r_odd;
        n_carry = r_carry;
        if (o_push) begin
            if (end_of_line) begin
                n_pos   = '0;
                n_odd   = 1'b0;
                n_carry = 2'b00;
            end else begin
                if (!r_odd) begin
                    n_carry = pair_dots[13:12];
                end
                n_odd = !r_odd;
                n_pos = r_pos + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_odd   <= 1'b0;
            r_carry <= 2'b00;
        end else begin
            r_pos   <= n_pos;
            r_odd   <= n_odd;
            r_carry <= n_carry;
        end
    end

endmodule
`default_nettype wire

### rtl/dhpd_queue.sv
`default_nettype none
module dhpd_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire dhpd_pkg::t_job  i_job,
    input  wire logic            i_pop,
    output logic                 o_full,
    output logic                 o_valid,
    output dhpd_pkg::t_job       o_job
);
    import dhpd_pkg::*;

    // Two-entry queue between front and back
    t_job       r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = !r_wr_ptr;
        end
        if (i_pop) begin
            n_rd_ptr = !r_rd_ptr;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule
`default_nettype wire

### rtl/dhpd_back.sv
`default_nettype none
module dhpd_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire dhpd_pkg::t_job  i_job,
    output logic                 o_pop,
    dhpd_pixel_if.source         o_pixel
);
    import dhpd_pkg::*;

    logic [PIX_W-1:0] r_k, n_k;
    logic             r_valid, n_valid;
    logic [31:0]      r_color;
    logic             r_last;
    logic             r_line_end;
    logic [PIX_W-1:0] last_k;
    logic             is_last;
    logic             load;
    logic [3:0]       nib;
    logic [31:0]      color;

    // Last pixel index per item kind
    always_comb begin
        if (i_job.mono) begin
            last_k = LAST_MONO;
        end else if (i_job.odd) begin
            last_k = LAST_ODD;
        end else begin
            last_k = LAST_EVEN;
        end
    end

    assign is_last = (r_k == last_k);
    assign load    = i_valid && (!r_valid || o_pixel.ready);
    assign o_pop   = load && is_last;

    // Color of the current pixel: one dot, or the nibble of its 4-pixel cell
    assign nib = i_job.dots[{r_k[3:2], 2'b00} +: 4];
    always_comb begin
        if (i_job.mono) begin
            color = i_job.dots[r_k] ? MONO_ON : MONO_OFF;
        end else begin
            color = palette(nib);
        end
    end

    always_comb begin
        n_k     = r_k;
        n_valid = r_valid;
        if (load) begin
            n_k     = is_last ? '0 : r_k + PIX_W'(1);
            n_valid = 1'b1;
        end else if (o_pixel.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k     <= '0;
            r_valid <= 1'b0;
        end else begin
            r_k     <= n_k;
            r_valid <= n_valid;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_color    <= color;
            r_last     <= is_last;
            r_line_end <= is_last && i_job.line_end;
        end
    end

    assign o_pixel.valid       = r_valid;
    assign o_pixel.pixel_color = r_color;
    assign o_pixel.last        = r_last;
    assign o_pixel.line_end    = r_line_end;

endmodule
`default_nettype wire

### rtl/double_hires_pixel_decoder.sv
// Channel   Dir  Payload                            Item
// i_pair    in   aux_byte[7:0], main_byte[7:0]      one aux/main byte pair
// o_pixel   out  pixel_color[31:0], last, line_end  one pixel
// cfg       in   i_cfg_wr_data (mono_mode)          register write
//
// One pixel leaves per cycle from the output register while the receiver is
// ready and an item is queued. The back-end pixel serializer sends 14 pixels
// per pair in monochrome, 12 (even pair) or 16 (odd pair) in color. A pair is
// taken whenever the two-entry queue has room, so input and output stall
// independently. Reset is synchronous, active low: clears mode, line
// position, parity, carried dots, the queue and the output valid.
`default_nettype none
module double_hires_pixel_decoder #(
    parameter int PAIRS_PER_LINE = 40
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_cfg_wr_en,
    input  wire logic     i_cfg_wr_data,
    dhpd_pair_if.sink     i_pair,
    dhpd_pixel_if.source  o_pixel
);
    import dhpd_pkg::*;

    logic r_mono_mode;
    logic push;
    logic pop;
    logic full;
    logic q_valid;
    t_job front_job;
    t_job back_job;

    // Mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mono_mode <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_mono_mode <= i_cfg_wr_data;
        end
    end

    dhpd_front #(
        .PAIRS_PER_LINE (PAIRS_PER_LINE)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mono  (r_mono_mode),
        .i_pair  (i_pair),
        .i_full  (full),
        .o_push  (push),
        .o_job   (front_job)
    );

    dhpd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_job   (back_job)
    );

    dhpd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_job   (back_job),
        .o_pop   (pop),
        .o_pixel (o_pixel)
    );

endmodule
`default_nettype wire

### rtl/dhpd_checker.sv
`default_nettype none
module dhpd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [31:0] i_out_color,
    input wire logic        i_out_last,
    input wire logic        i_out_line_end
);

    // No pixel right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("pixel valid after reset");

    // A stalled pixel keeps its valid and payload
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_color)
            && $stable(i_out_last) && $stable(i_out_line_end))
        else $error("stalled pixel changed");

    // The line ends only on the final pixel of an item
    a_line_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_line_end |-> i_out_last)
        else $error("line_end without last");

    // Every color is opaque
    a_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_color[31:24] == 8'hFF)
        else $error("alpha not opaque");

endmodule

bind double_hires_pixel_decoder dhpd_checker u_dhpd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_pixel.valid),
    .i_out_ready    (o_pixel.ready),
    .i_out_color    (o_pixel.pixel_color),
    .i_out_last     (o_pixel.last),
    .i_out_line_end (o_pixel.line_end)
);
`default_nettype wire
